// File: sv/tlrb_pkg.sv
`default_nettype none

package tlrb_pkg;

    localparam int unsigned STORE_DEPTH_DEF = 256;
    localparam int unsigned LINE_CHARS_DEF  = 30;
    localparam int unsigned SHOWN_LINES_DEF = 4;

    localparam logic [7:0] NEWLINE_CODE    = 8'd10;
    localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [6:0] HEADER_PIXELS   = 7'd23;
    localparam logic [6:0] ROW_PITCH       = 7'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPEND,
        ST_WALK,
        ST_EMIT
    } t_state;

    function automatic logic [5:0] pixel_row_of(input logic [2:0] row);
        logic [6:0] sum;
        sum = HEADER_PIXELS + ROW_PITCH * {4'd0, row};
        return sum[5:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/tlrb_in_if.sv
`default_nettype none

interface tlrb_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] char_code;
    logic [2:0] line_request;

    modport source (output valid, output mode, output char_code, output line_request,
                    input ready);
    modport sink (input valid, input mode, input char_code, input line_request,
                  output ready);
endinterface

`default_nettype wire

// File: sv/tlrb_out_if.sv
`default_nettype none

interface tlrb_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] row_index;
    logic [4:0] column;
    logic [7:0] char_out;
    logic       present;
    logic [5:0] pixel_row;
    logic       last;

    modport source (output valid, output row_index, output column, output char_out,
                    output present, output pixel_row, output last, input ready);
    modport sink (input valid, input row_index, input column, input char_out,
                  input present, input pixel_row, input last, output ready);
endinterface

`default_nettype wire

// File: sv/tlrb_text_ram.sv
`default_nettype none

module tlrb_text_ram #(
    parameter int unsigned DEPTH = tlrb_pkg::STORE_DEPTH_DEF,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: sv/text_log_ring_line_buffer_unit.sv
`default_nettype none

// Circular console text log. An append beat stores one character; control codes other
// than newline are ignored and not stored. A read beat walks the stored characters from
// the first shown line toward the write point (at most STORE_DEPTH - 1), then emits the
// result beats (1 to LINE_CHARS). The walk runs at one text RAM read per cycle; the
// emission does too, but holds while the sink is not ready.
// The input is not ready while a beat is in work; a finished result waits in the output
// register while the next input beat is taken.
module text_log_ring_line_buffer_unit #(
    parameter int unsigned STORE_DEPTH = tlrb_pkg::STORE_DEPTH_DEF,
    parameter int unsigned LINE_CHARS  = tlrb_pkg::LINE_CHARS_DEF,
    parameter int unsigned SHOWN_LINES = tlrb_pkg::SHOWN_LINES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tlrb_in_if.sink       i_in,
    tlrb_out_if.source    o_out
);
    import tlrb_pkg::*;

    localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);
    localparam int unsigned POS_W  = $clog2(LINE_CHARS + 1);
    localparam int unsigned SLOT_W = (SHOWN_LINES > 1) ? $clog2(SHOWN_LINES) : 1;
    localparam int unsigned HELD_W = $clog2(SHOWN_LINES + 1);
    localparam int unsigned CMP_W  = (HELD_W > 3) ? HELD_W : 3;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [POS_W-1:0]  LINE_MAX  = POS_W'(LINE_CHARS);
    localparam logic [HELD_W-1:0] HELD_MAX  = HELD_W'(SHOWN_LINES);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SHOWN_LINES - 1);

    function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + ADDR_W'(1);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
    endfunction

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_wp, n_wp;
    logic [ADDR_W-1:0]   r_op, n_op;
    logic [ADDR_W-1:0]   r_table [SHOWN_LINES];
    logic [SLOT_W-1:0]   r_nls, n_nls;
    logic [HELD_W-1:0]   r_held, n_held;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [7:0]          r_char, n_char;
    logic [2:0]          r_row, n_row;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [HELD_W-1:0]   r_drawn, n_drawn;
    logic [ADDR_W-1:0]   r_lstart, n_lstart;
    logic [POS_W-1:0]    r_len, n_len;
    logic [POS_W-1:0]    r_k, n_k;

    logic                r_ovalid, n_ovalid;
    logic [2:0]          r_o_row, n_o_row;
    logic [4:0]          r_o_col, n_o_col;
    logic [7:0]          r_o_char, n_o_char;
    logic                r_o_present, n_o_present;
    logic [5:0]          r_o_pix, n_o_pix;
    logic                r_o_last, n_o_last;

    logic [7:0]          rd_data;
    logic                in_fire;
    logic                storable;
    logic                ram_we;
    logic                at_end;
    logic                brk;
    logic                row_match;
    logic                hit;
    logic                load;
    logic                emit_last;
    logic [ADDR_W-1:0]   wp_next;
    logic [ADDR_W-1:0]   start_addr;
    logic [HELD_W-1:0]   held_mid;

    tlrb_text_ram #(
        .DEPTH(STORE_DEPTH)
    ) u_text_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(r_wp),
        .i_wr_data(i_in.char_code),
        .i_rd_addr(n_addr),
        .o_rd_data(rd_data)
    );

    assign in_fire    = i_in.valid && i_in.ready;
    assign storable   = (i_in.char_code >= FIRST_PRINTABLE) || (i_in.char_code == NEWLINE_CODE);
    assign ram_we     = in_fire && !i_in.mode && storable;
    assign at_end     = (r_addr == r_wp);
    assign brk        = (rd_data == NEWLINE_CODE) || (r_pos >= LINE_MAX);
    assign row_match  = (CMP_W'(r_drawn) == CMP_W'(r_row));
    assign hit        = brk && (r_drawn < HELD_MAX) && row_match;
    assign load       = !r_ovalid || o_out.ready;
    assign emit_last  = (r_len == '0) || ((r_k + POS_W'(1)) == r_len);
    assign wp_next    = addr_inc(r_wp);
    assign start_addr = (r_held < HELD_MAX) ? r_op : r_table[r_nls];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.mode) begin
                        n_state = ST_WALK;
                    end else if (storable) begin
                        n_state = ST_APPEND;
                    end
                end
            end
            ST_APPEND: n_state = ST_IDLE;
            ST_WALK: begin
                if (at_end || hit) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (load && emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = (r_state == ST_IDLE);
        n_wp        = r_wp;
        n_op        = r_op;
        n_nls       = r_nls;
        n_held      = r_held;
        n_addr      = r_addr;
        n_char      = r_char;
        n_row       = r_row;
        n_pos       = r_pos;
        n_drawn     = r_drawn;
        n_lstart    = r_lstart;
        n_len       = r_len;
        n_k         = r_k;
        n_ovalid    = r_ovalid && !o_out.ready;
        n_o_row     = r_o_row;
        n_o_col     = r_o_col;
        n_o_char    = r_o_char;
        n_o_present = r_o_present;
        n_o_pix     = r_o_pix;
        n_o_last    = r_o_last;
        held_mid    = r_held;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (i_in.mode) begin
                        n_row    = i_in.line_request;
                        n_pos    = '0;
                        n_drawn  = '0;
                        n_addr   = start_addr;
                        n_lstart = start_addr;
                    end else begin
                        n_char = i_in.char_code;
                        n_addr = r_op;
                    end
                end
            end
            ST_APPEND: begin
                // The store is full when the advanced write point meets the oldest character.
                n_wp = wp_next;
                if (wp_next == r_op) begin
                    if (rd_data == NEWLINE_CODE && r_held != '0) begin
                        held_mid = r_held - HELD_W'(1);
                    end
                    n_op = addr_inc(r_op);
                end
                if (r_char == NEWLINE_CODE) begin
                    n_nls = slot_inc(r_nls);
                    if (held_mid < HELD_MAX) begin
                        held_mid = held_mid + HELD_W'(1);
                    end
                end
                n_held = held_mid;
            end
            ST_WALK: begin
                if (at_end) begin
                    n_len  = (r_pos != '0 && row_match) ? r_pos : '0;
                    n_addr = r_lstart;
                    n_k    = '0;
                end else if (hit) begin
                    n_len  = r_pos;
                    n_addr = r_lstart;
                    n_k    = '0;
                end else if (brk) begin
                    if (r_drawn < HELD_MAX) begin
                        n_drawn = r_drawn + HELD_W'(1);
                    end
                    n_pos    = '0;
                    n_addr   = addr_inc(r_addr);
                    n_lstart = addr_inc(r_addr);
                end else begin
                    n_pos  = r_pos + POS_W'(1);
                    n_addr = addr_inc(r_addr);
                end
            end
            ST_EMIT: begin
                if (load) begin
                    n_ovalid    = 1'b1;
                    n_o_row     = r_row;
                    n_o_col     = 5'(r_k);
                    n_o_char    = (r_len == '0) ? 8'd0 : rd_data;
                    n_o_present = (r_len != '0);
                    n_o_pix     = pixel_row_of(r_row);
                    n_o_last    = emit_last;
                    n_k         = r_k + POS_W'(1);
                    n_addr      = addr_inc(r_addr);
                end
            end
            default: begin
                n_ovalid = r_ovalid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_wp     <= '0;
            r_op     <= '0;
            r_nls    <= '0;
            r_held   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wp     <= n_wp;
            r_op     <= n_op;
            r_nls    <= n_nls;
            r_held   <= n_held;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_APPEND && r_char == NEWLINE_CODE) begin
            r_table[r_nls] <= wp_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_char      <= n_char;
        r_row       <= n_row;
        r_pos       <= n_pos;
        r_drawn     <= n_drawn;
        r_lstart    <= n_lstart;
        r_len       <= n_len;
        r_k         <= n_k;
        r_o_row     <= n_o_row;
        r_o_col     <= n_o_col;
        r_o_char    <= n_o_char;
        r_o_present <= n_o_present;
        r_o_pix     <= n_o_pix;
        r_o_last    <= n_o_last;
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.row_index = r_o_row;
    assign o_out.column    = r_o_col;
    assign o_out.char_out  = r_o_char;
    assign o_out.present   = r_o_present;
    assign o_out.pixel_row = r_o_pix;
    assign o_out.last      = r_o_last;

endmodule

`default_nettype wire

// File: verif/tb.sv
module tb;
    import tlrb_pkg::*;

    localparam int unsigned DEPTH = STORE_DEPTH_DEF;
    localparam int unsigned LINE  = LINE_CHARS_DEF;
    localparam int unsigned SHOWN = SHOWN_LINES_DEF;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    localparam int unsigned TOTAL_ITEMS    = 480;
    localparam int unsigned CALM_AFTER     = 400;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 320;
    localparam int unsigned MAX_REPORTED   = 10;
    localparam int unsigned N_DIRECTED     = 21;

    typedef struct packed {
        logic [2:0] row;
        logic [4:0] col;
        logic [7:0] ch;
        logic       present;
        logic [5:0] pix;
        logic       last;
    } t_glyph;

    typedef struct packed {
        logic       mode;
        logic [7:0] ch;
        logic [2:0] req;
        logic       typed;
        t_glyph     want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tlrb_in_if  in_if ();
    tlrb_out_if out_if ();

    text_log_ring_line_buffer_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the console log.
    logic [7:0]  log_text [DEPTH];
    int unsigned log_head;
    int unsigned log_tail;
    int unsigned line_marks [SHOWN];
    int unsigned mark_slot;
    int unsigned marks_held;

    t_glyph      pending_glyphs [$];
    t_glyph      seen;
    t_glyph      want;
    int unsigned miss_count = 0;
    int unsigned counted = 0;
    int unsigned quiet_cycles = 0;
    bit          calm = 1'b0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{MODE_READ,   8'd0,   3'd0, 1'b1, '{3'd0, 5'd0, 8'd0,  1'b0, 6'd23, 1'b1}},
        '{MODE_READ,   8'd0,   3'd7, 1'b1, '{3'd7, 5'd0, 8'd0,  1'b0, 6'd29, 1'b1}},
        '{MODE_READ,   8'd0,   3'd4, 1'b1, '{3'd4, 5'd0, 8'd0,  1'b0, 6'd63, 1'b1}},
        '{MODE_APPEND, 8'd0,   3'd0, 1'b0, '0},
        '{MODE_APPEND, 8'd31,  3'd0, 1'b0, '0},
        '{MODE_APPEND, 8'd9,   3'd0, 1'b0, '0},
        '{MODE_APPEND, 8'd65,  3'd0, 1'b0, '0},
        '{MODE_READ,   8'd0,   3'd0, 1'b1, '{3'd0, 5'd0, 8'd65, 1'b1, 6'd23, 1'b1}},
        '{MODE_APPEND, 8'd255, 3'd0, 1'b0, '0},
        '{MODE_APPEND, 8'd32,  3'd0, 1'b0, '0},
        '{MODE_APPEND, NEWLINE_CODE, 3'd0, 1'b0, '0},
        '{MODE_READ,   8'd0,   3'd0, 1'b0, '0},
        '{MODE_READ,   8'd0,   3'd1, 1'b0, '0},
        '{MODE_APPEND, 8'd127, 3'd0, 1'b0, '0},
        '{MODE_APPEND, NEWLINE_CODE, 3'd0, 1'b0, '0},
        '{MODE_APPEND, NEWLINE_CODE, 3'd0, 1'b0, '0},
        '{MODE_READ,   8'd0,   3'd1, 1'b0, '0},
        '{MODE_READ,   8'd0,   3'd2, 1'b0, '0},
        '{MODE_READ,   8'd0,   3'd3, 1'b0, '0},
        '{MODE_READ,   8'd0,   3'd5, 1'b0, '0},
        '{MODE_READ,   8'd0,   3'd6, 1'b0, '0}
    };

    function automatic void log_append(input logic [7:0] c);
        if (c < FIRST_PRINTABLE && c != NEWLINE_CODE) return;
        log_text[log_head] = c;
        log_head = (log_head + 1) % DEPTH;
        if (log_head == log_tail) begin
            if (log_text[log_tail] == NEWLINE_CODE && marks_held > 0) marks_held--;
            log_tail = (log_tail + 1) % DEPTH;
        end
        if (c == NEWLINE_CODE) begin
            line_marks[mark_slot] = log_head;
            mark_slot = (mark_slot + 1) % SHOWN;
            if (marks_held < SHOWN) marks_held++;
        end
    endfunction

    // Walks the log the way the display does and queues the beats of one row.
    function automatic void predict_row(input logic [2:0] req);
        logic [7:0]  line_buf [LINE];
        int unsigned pos;
        int unsigned drawn;
        int unsigned i;
        int unsigned steps;
        int unsigned p;
        bit          found;
        logic [7:0]  ch;
        pos = 0;
        drawn = 0;
        found = 1'b0;
        if (marks_held < SHOWN) i = log_tail;
        else i = line_marks[(mark_slot + SHOWN - (marks_held % (SHOWN + 1))) % SHOWN];
        i = i % DEPTH;
        for (steps = 0; steps < DEPTH && i != log_head && !found; steps++) begin
            ch = log_text[i];
            if (ch == NEWLINE_CODE || pos >= LINE) begin
                if (drawn < SHOWN) begin
                    if (drawn == req) found = 1'b1;
                    else drawn++;
                end
                if (!found) pos = 0;
            end else begin
                line_buf[pos] = ch;
                pos++;
            end
            i = (i + 1) % DEPTH;
        end
        if (!found && drawn != req) pos = 0;
        p = HEADER_PIXELS + ROW_PITCH * req;
        if (pos == 0) begin
            pending_glyphs.push_back('{req, 5'd0, 8'd0, 1'b0, p[5:0], 1'b1});
        end else begin
            for (int unsigned k = 0; k < pos; k++) begin
                pending_glyphs.push_back('{req, k[4:0], line_buf[k], 1'b1, p[5:0],
                                           (k + 1 == pos)});
            end
        end
    endfunction

    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 31));
        return 8'($urandom_range(32, 255));
    endfunction

    task automatic report_miss(input string what, input t_glyph got, input t_glyph exp_g);
        miss_count++;
        if (miss_count <= MAX_REPORTED) begin
            $display("%0t %s: got row %0d col %0d ch %02h present %0b pix %0d last %0b",
                     $time, what, got.row, got.col, got.ch, got.present, got.pix, got.last);
            $display("    expected row %0d col %0d ch %02h present %0b pix %0d last %0b",
                     exp_g.row, exp_g.col, exp_g.ch, exp_g.present, exp_g.pix, exp_g.last);
        end
    endtask

    task automatic drive_beat(input logic m, input logic [7:0] c, input logic [2:0] r,
                              input logic typed, input t_glyph typed_glyph);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.mode         <= m;
        in_if.char_code    <= c;
        in_if.line_request <= r;
        do @(posedge i_clk); while (!in_if.ready);
        if (m == MODE_APPEND) begin
            log_append(c);
            if (c >= FIRST_PRINTABLE || c == NEWLINE_CODE) counted++;
        end else begin
            counted++;
            if (typed) pending_glyphs.push_back(typed_glyph);
            else predict_row(r);
        end
        if (counted >= CALM_AFTER) calm = 1'b1;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen = '{out_if.row_index, out_if.column, out_if.char_out, out_if.present,
                     out_if.pixel_row, out_if.last};
            if (pending_glyphs.size() == 0) begin
                report_miss("unexpected beat", seen, '0);
            end else begin
                want = pending_glyphs.pop_front();
                if (seen !== want) report_miss("mismatch", seen, want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("** text_log_ring_line_buffer_unit: FAILED **");
                $finish;
            end
        end
    end

    always begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 4)) @(posedge i_clk);
        else repeat ($urandom_range(10, 60)) @(posedge i_clk);
        if (!calm) begin
            out_if.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    end

    initial begin
        int unsigned style;
        int unsigned seg_len;
        logic [2:0]  req;
        log_head = 0;
        log_tail = 0;
        mark_slot = 0;
        marks_held = 0;
        in_if.valid        <= 1'b0;
        in_if.mode         <= MODE_APPEND;
        in_if.char_code    <= 8'd0;
        in_if.line_request <= 3'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            drive_beat(directed_rows[n].mode, directed_rows[n].ch, directed_rows[n].req,
                       directed_rows[n].typed, directed_rows[n].want);
        end

        // Mostly well-formed text with short or long lines, plus some noise.
        while (counted < TOTAL_ITEMS) begin
            style = $urandom_range(0, 9);
            if (style <= 5) begin
                seg_len = $urandom_range(0, 20);
                repeat (seg_len) drive_beat(MODE_APPEND, text_byte(), 3'd0, 1'b0, '0);
                drive_beat(MODE_APPEND, NEWLINE_CODE, 3'd0, 1'b0, '0);
            end else if (style <= 7) begin
                seg_len = $urandom_range(25, 70);
                repeat (seg_len) drive_beat(MODE_APPEND, text_byte(), 3'd0, 1'b0, '0);
                if ($urandom_range(0, 1) == 0)
                    drive_beat(MODE_APPEND, NEWLINE_CODE, 3'd0, 1'b0, '0);
            end else if (style == 8) begin
                repeat ($urandom_range(1, 6)) begin
                    drive_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                               3'($urandom_range(0, 7)), 1'b0, '0);
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    drive_beat(MODE_APPEND, NEWLINE_CODE, 3'd0, 1'b0, '0);
            end
            repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(0, 7) == 0) req = 3'($urandom_range(5, 7));
                else req = 3'($urandom_range(0, 4));
                drive_beat(MODE_READ, 8'($urandom_range(0, 255)), req, 1'b0, '0);
            end
        end

        in_if.valid <= 1'b0;
        while (pending_glyphs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (miss_count == 0 && pending_glyphs.size() == 0) begin
            $display("** text_log_ring_line_buffer_unit: PASSED **");
        end else begin
            $display("** text_log_ring_line_buffer_unit: FAILED **");
        end
        $finish;
    end

endmodule

// File: text_log_ring_line_buffer_unit.f
sv/tlrb_pkg.sv
sv/tlrb_in_if.sv
sv/tlrb_out_if.sv
sv/tlrb_text_ram.sv
sv/text_log_ring_line_buffer_unit.sv
verif/tb.sv
